>>> rtl/psm_pkg.sv
// psm_pkg: types, constants and helper functions for the saturation-maximize pipeline
// used by pixel_saturation_maximize; depends on nothing else
`default_nettype none

package psm_pkg;

  // channel widths and internal widths
  localparam int unsigned ChanW  = 8;
  localparam int unsigned QuoW   = 6;   // hue quotient 0..60
  localparam int unsigned DvdW   = 14;  // 60 * |num| <= 15300
  localparam int unsigned HueW   = 9;   // hue 0..359
  localparam int unsigned ProdW  = 14;  // k * value <= 15300

  // hue offsets per largest channel
  localparam logic [HueW-1:0] HUE_OFF_GREEN = 9'd120;
  localparam logic [HueW-1:0] HUE_OFF_BLUE  = 9'd240;
  localparam logic [HueW-1:0] HUE_FULL      = 9'd360;

  // sector boundaries
  localparam logic [HueW-1:0] HUE_60  = 9'd60;
  localparam logic [HueW-1:0] HUE_120 = 9'd120;
  localparam logic [HueW-1:0] HUE_180 = 9'd180;
  localparam logic [HueW-1:0] HUE_240 = 9'd240;
  localparam logic [HueW-1:0] HUE_300 = 9'd300;

  // divide by 60 through reciprocal: floor(x / 60) = (x * 17477) >> 20 for x < 23831
  localparam int unsigned     RecipW     = 15;
  localparam logic [RecipW-1:0] RECIP_60 = 15'd17477;
  localparam int unsigned     RecipShift = 20;

  // largest channel select, with red then green then blue priority
  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_sel_t;

  // hue sector
  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_t;

  // one restoring division step
  typedef struct packed {
    logic [DvdW-1:0] rem;
    logic            qbit;
  } div_step_t;

  function automatic div_step_t div_step(input logic [DvdW-1:0] rem,
                                         input logic [DvdW-1:0] dvs);
    div_step_t res;
    if (rem >= dvs) begin
      res.rem  = rem - dvs;
      res.qbit = 1'b1;
    end else begin
      res.rem  = rem;
      res.qbit = 1'b0;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/pixel_saturation_maximize.sv
// throughput: one pixel per clock; seven register stages (channel sort, three
// radix-4 division stages, hue/sector, product, reciprocal scale) each advance when
// the stage after them is empty or moving, so bubbles collapse under stall
// reset: rst (synchronous, active high) clears every stage valid; data registers keep
// their contents
`default_nettype none

module pixel_saturation_maximize (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] red_in,
  input  wire logic [7:0] green_in,
  input  wire logic [7:0] blue_in,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      red_out,
  output logic [7:0]      green_out,
  output logic [7:0]      blue_out
);

  localparam int unsigned CW = psm_pkg::ChanW;
  localparam int unsigned QW = psm_pkg::QuoW;
  localparam int unsigned DW = psm_pkg::DvdW;
  localparam int unsigned HW = psm_pkg::HueW;
  localparam int unsigned PW = psm_pkg::ProdW;
  localparam int unsigned MW = psm_pkg::ProdW + psm_pkg::RecipW;

  // stage valids and advance enables
  logic v1, v2, v3, v4, v5, v6, v7;
  logic en1, en2, en3, en4, en5, en6, en7;

  always_comb begin
    en7 = !v7 || !out_stall;
    en6 = !v6 || en7;
    en5 = !v5 || en6;
    en4 = !v4 || en5;
    en3 = !v3 || en4;
    en2 = !v2 || en3;
    en1 = !v1 || en2;
  end

  assign in_stall  = !en1;
  assign out_valid = v7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
      if (en7) v7 <= v6;
    end
  end

  // stage 1: largest, smallest, numerator sign and dividend 60 * |num|
  logic [CW-1:0]       mx_c, mn_c, abs_c;
  logic signed [CW:0]  num_c;
  psm_pkg::chan_sel_t  sel_c;

  always_comb begin
    if (red_in >= green_in && red_in >= blue_in) begin
      mx_c  = red_in;
      num_c = $signed({1'b0, green_in}) - $signed({1'b0, blue_in});
      sel_c = psm_pkg::CH_RED;
    end else if (green_in >= blue_in) begin
      mx_c  = green_in;
      num_c = $signed({1'b0, blue_in}) - $signed({1'b0, red_in});
      sel_c = psm_pkg::CH_GREEN;
    end else begin
      mx_c  = blue_in;
      num_c = $signed({1'b0, red_in}) - $signed({1'b0, green_in});
      sel_c = psm_pkg::CH_BLUE;
    end
    mn_c = red_in;
    if (green_in < mn_c) mn_c = green_in;
    if (blue_in < mn_c) mn_c = blue_in;
    abs_c = num_c[CW] ? CW'(-num_c) : num_c[CW-1:0];
  end

  logic [CW-1:0]      mx1, delta1;
  logic [DW-1:0]      dvd1;
  logic               neg1, grey1;
  psm_pkg::chan_sel_t sel1;

  always_ff @(posedge clk) begin
    if (en1) begin
      mx1    <= mx_c;
      delta1 <= mx_c - mn_c;
      dvd1   <= (DW'(abs_c) << 6) - (DW'(abs_c) << 2);
      neg1   <= num_c[CW];
      grey1  <= (mx_c == mn_c);
      sel1   <= sel_c;
    end
  end

  // stage 2: quotient bits 5 and 4
  psm_pkg::div_step_t st5, st4;
  assign st5 = psm_pkg::div_step(dvd1, DW'(delta1) << 5);
  assign st4 = psm_pkg::div_step(st5.rem, DW'(delta1) << 4);

  logic [CW-1:0]      mx2, delta2;
  logic [DW-1:0]      rem2;
  logic [1:0]         q2;
  logic               neg2, grey2;
  psm_pkg::chan_sel_t sel2;

  always_ff @(posedge clk) begin
    if (en2) begin
      mx2    <= mx1;
      delta2 <= delta1;
      rem2   <= st4.rem;
      q2     <= {st5.qbit, st4.qbit};
      neg2   <= neg1;
      grey2  <= grey1;
      sel2   <= sel1;
    end
  end

  // stage 3: quotient bits 3 and 2
  psm_pkg::div_step_t st3, st2;
  assign st3 = psm_pkg::div_step(rem2, DW'(delta2) << 3);
  assign st2 = psm_pkg::div_step(st3.rem, DW'(delta2) << 2);

  logic [CW-1:0]      mx3, delta3;
  logic [DW-1:0]      rem3;
  logic [3:0]         q3;
  logic               neg3, grey3;
  psm_pkg::chan_sel_t sel3;

  always_ff @(posedge clk) begin
    if (en3) begin
      mx3    <= mx2;
      delta3 <= delta2;
      rem3   <= st2.rem;
      q3     <= {q2, st3.qbit, st2.qbit};
      neg3   <= neg2;
      grey3  <= grey2;
      sel3   <= sel2;
    end
  end

  // stage 4: quotient bits 1 and 0
  psm_pkg::div_step_t st1, st0;
  assign st1 = psm_pkg::div_step(rem3, DW'(delta3) << 1);
  assign st0 = psm_pkg::div_step(st1.rem, DW'(delta3));

  logic [CW-1:0]      mx4;
  logic [QW-1:0]      q4;
  logic               neg4, grey4;
  psm_pkg::chan_sel_t sel4;

  always_ff @(posedge clk) begin
    if (en4) begin
      mx4   <= mx3;
      q4    <= {q3, st1.qbit, st0.qbit};
      neg4  <= neg3;
      grey4 <= grey3;
      sel4  <= sel3;
    end
  end

  // stage 5: hue, sector and distance into the sector
  logic [HW-1:0]      off_c, hue_c;
  logic signed [HW:0] hue_s;
  psm_pkg::sector_t   sec_c;
  logic [HW-1:0]      kw_c;

  always_comb begin
    case (sel4)
      psm_pkg::CH_GREEN: off_c = psm_pkg::HUE_OFF_GREEN;
      psm_pkg::CH_BLUE:  off_c = psm_pkg::HUE_OFF_BLUE;
      default:           off_c = '0;
    endcase
    if (neg4) begin
      hue_s = $signed({1'b0, off_c}) - $signed({4'b0, q4});
    end else begin
      hue_s = $signed({1'b0, off_c}) + $signed({4'b0, q4});
    end
    if (grey4) begin
      hue_c = '0;
    end else if (hue_s < 0) begin
      hue_c = HW'(hue_s + $signed({1'b0, psm_pkg::HUE_FULL}));
    end else begin
      hue_c = hue_s[HW-1:0];
    end

    if (hue_c < psm_pkg::HUE_60) begin
      sec_c = psm_pkg::SEC_0;
      kw_c  = hue_c;
    end else if (hue_c < psm_pkg::HUE_120) begin
      sec_c = psm_pkg::SEC_1;
      kw_c  = psm_pkg::HUE_120 - hue_c;
    end else if (hue_c < psm_pkg::HUE_180) begin
      sec_c = psm_pkg::SEC_2;
      kw_c  = hue_c - psm_pkg::HUE_120;
    end else if (hue_c < psm_pkg::HUE_240) begin
      sec_c = psm_pkg::SEC_3;
      kw_c  = psm_pkg::HUE_240 - hue_c;
    end else if (hue_c < psm_pkg::HUE_300) begin
      sec_c = psm_pkg::SEC_4;
      kw_c  = hue_c - psm_pkg::HUE_240;
    end else begin
      sec_c = psm_pkg::SEC_5;
      kw_c  = psm_pkg::HUE_FULL - hue_c;
    end
  end

  logic [CW-1:0]    val5;
  logic [QW-1:0]    k5;
  psm_pkg::sector_t sec5;

  always_ff @(posedge clk) begin
    if (en5) begin
      val5 <= mx4;
      k5   <= kw_c[QW-1:0];
      sec5 <= sec_c;
    end
  end

  // stage 6: k * value
  logic [CW-1:0]    val6;
  logic [PW-1:0]    prod6;
  psm_pkg::sector_t sec6;

  always_ff @(posedge clk) begin
    if (en6) begin
      val6  <= val5;
      prod6 <= PW'(k5 * val5);
      sec6  <= sec5;
    end
  end

  // stage 7: divide by 60 through the reciprocal and place channels by sector
  logic [MW-1:0] scaled_c;
  logic [CW-1:0] mid_c;

  assign scaled_c = MW'(prod6) * MW'(psm_pkg::RECIP_60);
  assign mid_c    = scaled_c[psm_pkg::RecipShift +: CW];

  always_ff @(posedge clk) begin
    if (en7) begin
      unique case (sec6)
        psm_pkg::SEC_0: begin
          red_out <= val6;  green_out <= mid_c; blue_out <= '0;
        end
        psm_pkg::SEC_1: begin
          red_out <= mid_c; green_out <= val6;  blue_out <= '0;
        end
        psm_pkg::SEC_2: begin
          red_out <= '0;    green_out <= val6;  blue_out <= mid_c;
        end
        psm_pkg::SEC_3: begin
          red_out <= '0;    green_out <= mid_c; blue_out <= val6;
        end
        psm_pkg::SEC_4: begin
          red_out <= mid_c; green_out <= '0;    blue_out <= val6;
        end
        default: begin
          red_out <= val6;  green_out <= '0;    blue_out <= mid_c;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/psm_checker.sv
// psm_checker: port-level assertions for pixel_saturation_maximize
// bound to the top level below; depends on the top level's port list only
`default_nettype none

module psm_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] red_out,
  input wire logic [7:0] green_out,
  input wire logic [7:0] blue_out
);

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // backpressure only appears when the output is held
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output not held");

  // a fully saturated pixel always has a zero channel
  a_zero_chan: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (red_out == 8'd0 || green_out == 8'd0 || blue_out == 8'd0))
    else $error("output pixel without a zero channel");

  // a held output transaction stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(red_out) && $stable(green_out) && $stable(blue_out)))
    else $error("held output transaction changed");

endmodule

bind pixel_saturation_maximize psm_checker u_psm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .red_out   (red_out),
  .green_out (green_out),
  .blue_out  (blue_out)
);

`default_nettype wire
